// ----- sv/tscm_pkg.sv -----
// Shared types, constants and helpers for the TLSF size-class mapper.
package tscm_pkg;

  // Field widths
  localparam int SizeW  = 32;
  localparam int FlW    = 5;
  localparam int SlW    = 5;
  localparam int AdjW   = 30;
  localparam int AlignW = 4;
  localparam int LgW    = 5;

  // Default second-level split (log2 of second-level classes)
  localparam int SlLog2Default = 5;

  // Adjust limits and reset alignment
  localparam logic [AlignW-1:0] AlignReset = 4'd2;
  localparam logic [SizeW-1:0]  BlockMin   = 32'd12;
  localparam logic [SizeW-1:0]  BlockMax   = 32'h4000_0000;

  // Operation codes
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_ADJUST = 2'd2
  } cmd_t;

  // Request transaction
  typedef struct packed {
    cmd_t             cmd;
    logic [SizeW-1:0] size;
  } req_t;

  // Result transaction
  typedef struct packed {
    logic [FlW-1:0]  fl_index;
    logic [SlW-1:0]  sl_index;
    logic [AdjW-1:0] adjusted_size;
  } rsp_t;

  // Index of the highest set bit; 0 for an input of 0
  function automatic logic [LgW-1:0] floor_log2(input logic [SizeW-1:0] v);
    logic [LgW-1:0] n;
    n = '0;
    for (int i = 1; i < SizeW; i++) begin
      if (v[i]) n = LgW'(i);
    end
    return n;
  endfunction

endpackage

// ----- sv/tlsf_size_class_mapper.sv -----
// TLSF size-class mapper: four-stage pipeline for insert, search and adjust.
// Throughput: one command per cycle, every cycle; busy is always low.
// Stages: encode + align add, search round add + clamp, re-encode, class shift.
// Reset (rst, synchronous): pipeline valid bits cleared, align_log2 set to 2.
// result_valid pulses one cycle per result; the receiver cannot stall.
module tlsf_size_class_mapper #(
  parameter int SL_LOG2 = tscm_pkg::SlLog2Default
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  tscm_pkg::req_t                item,
  output logic                          result_valid,
  output tscm_pkg::rsp_t                result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tscm_pkg::AlignW-1:0]   cfg_data
);

  localparam int FlShift  = SL_LOG2 + 2;
  localparam int DivShift = FlShift - SL_LOG2;
  localparam logic [tscm_pkg::SizeW-1:0] SlCount = tscm_pkg::SizeW'(1) << SL_LOG2;
  localparam logic [tscm_pkg::LgW-1:0]   SlLg    = tscm_pkg::LgW'(SL_LOG2);
  localparam logic [tscm_pkg::LgW-1:0]   FlBias  = tscm_pkg::LgW'(FlShift - 1);
  localparam logic [tscm_pkg::FlW-1:0]   FlMax   = tscm_pkg::FlW'(32 - FlShift);

  // No back-pressure anywhere
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  logic in_fire;
  assign in_fire = start & ~busy;

  // Alignment register
  logic [tscm_pkg::AlignW-1:0] align_log2;
  always_ff @(posedge clk) begin
    if (rst) begin
      align_log2 <= tscm_pkg::AlignReset;
    end else if (cfg_valid && cfg_ready) begin
      align_log2 <= cfg_data;
    end
  end

  // Stage 1: encode input size, align-up add
  logic [tscm_pkg::SizeW-1:0] align_mask;
  logic [tscm_pkg::SizeW-1:0] s1_aligned_next;
  assign align_mask      = (tscm_pkg::SizeW'(1) << align_log2) - tscm_pkg::SizeW'(1);
  assign s1_aligned_next = (item.size + align_mask) & ~align_mask;

  logic                       s1_valid;
  tscm_pkg::cmd_t             s1_cmd;
  logic [tscm_pkg::SizeW-1:0] s1_size;
  logic [tscm_pkg::LgW-1:0]   s1_lg;
  logic [tscm_pkg::SizeW-1:0] s1_aligned;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= in_fire;
    s1_cmd     <= item.cmd;
    s1_size    <= item.size;
    s1_lg      <= tscm_pkg::floor_log2(item.size);
    s1_aligned <= s1_aligned_next;
  end

  // Stage 2: search round-up (wraps at 32 bits), adjust clamp
  logic                       s1_big;
  logic [tscm_pkg::SizeW-1:0] round_add;
  logic [tscm_pkg::SizeW-1:0] s2_map_size_next;
  logic [tscm_pkg::AdjW-1:0]  s2_adjusted_next;

  assign s1_big    = (s1_size >> FlShift) != '0;
  assign round_add = (tscm_pkg::SizeW'(1) << (s1_lg - SlLg)) - tscm_pkg::SizeW'(1);

  always_comb begin
    s2_map_size_next = s1_size;
    if (s1_cmd == tscm_pkg::CMD_SEARCH && s1_big) s2_map_size_next = s1_size + round_add;
    s2_adjusted_next = '0;
    if (s1_cmd == tscm_pkg::CMD_ADJUST && s1_size != '0 && s1_aligned < tscm_pkg::BlockMax) begin
      if (s1_aligned < tscm_pkg::BlockMin) s2_adjusted_next = tscm_pkg::AdjW'(tscm_pkg::BlockMin);
      else                                 s2_adjusted_next = s1_aligned[tscm_pkg::AdjW-1:0];
    end
  end

  logic                       s2_valid;
  tscm_pkg::cmd_t             s2_cmd;
  logic [tscm_pkg::SizeW-1:0] s2_map_size;
  logic [tscm_pkg::AdjW-1:0]  s2_adjusted;

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else     s2_valid <= s1_valid;
    s2_cmd      <= s1_cmd;
    s2_map_size <= s2_map_size_next;
    s2_adjusted <= s2_adjusted_next;
  end

  // Stage 3: encode the size to be mapped
  logic                       s3_valid;
  tscm_pkg::cmd_t             s3_cmd;
  logic [tscm_pkg::SizeW-1:0] s3_map_size;
  logic [tscm_pkg::LgW-1:0]   s3_lg;
  logic                       s3_small;
  logic [tscm_pkg::AdjW-1:0]  s3_adjusted;

  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else     s3_valid <= s2_valid;
    s3_cmd      <= s2_cmd;
    s3_map_size <= s2_map_size;
    s3_lg       <= tscm_pkg::floor_log2(s2_map_size);
    s3_small    <= (s2_map_size >> FlShift) == '0;
    s3_adjusted <= s2_adjusted;
  end

  // Stage 4: class shift into the output register
  tscm_pkg::rsp_t result_next;

  always_comb begin
    result_next               = '0;
    result_next.adjusted_size = s3_adjusted;
    case (s3_cmd)
      tscm_pkg::CMD_INSERT, tscm_pkg::CMD_SEARCH: begin
        if (s3_small) begin
          result_next.sl_index = tscm_pkg::SlW'(s3_map_size >> DivShift);
        end else begin
          result_next.fl_index = tscm_pkg::FlW'(s3_lg - FlBias);
          result_next.sl_index = tscm_pkg::SlW'(s3_map_size >> (s3_lg - SlLg))
                                 ^ SlCount[tscm_pkg::SlW-1:0];
        end
      end
      default: begin
        result_next.fl_index = '0;
        result_next.sl_index = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else     result_valid <= s3_valid;
    result <= result_next;
  end

  // Checks
  a_valid_follows: assert property (@(posedge clk) disable iff (rst)
    s3_valid |=> result_valid)
    else $error("result strobe lost");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    !s3_valid |=> !result_valid)
    else $error("result strobe without a transaction");

  a_fields_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.adjusted_size == '0 ||
                      (result.fl_index == '0 && result.sl_index == '0)))
    else $error("class and adjusted size both set");

  a_adj_min: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.adjusted_size == '0 ||
                      result.adjusted_size >= tscm_pkg::AdjW'(tscm_pkg::BlockMin)))
    else $error("adjusted size below minimum block");

  a_fl_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.fl_index <= FlMax)
    else $error("first level out of range");

endmodule

// ----- tb/tlsf_size_class_mapper_tb.sv -----
// Self-checking testbench for the TLSF size-class mapper: directed table, then random phases.
module tlsf_size_class_mapper_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Mapping constants for the default second-level split
  localparam int          SlBits       = tscm_pkg::SlLog2Default;
  localparam int          FlShift      = SlBits + 2;
  localparam logic [31:0] SmallBound   = 32'd1 << FlShift;
  localparam logic [31:0] SmallDivisor = SmallBound >> SlBits;
  localparam logic [31:0] SlCount      = 32'd1 << SlBits;

  // Operation code outside the defined set
  localparam logic [1:0] CmdUnknown = 2'd3;

  localparam int LatencyCycles = 4;
  localparam int StallLimit    = 1000;
  localparam int PhaseItems    = 125;
  localparam int ReportLimit   = 10;
  localparam int DirN          = 22;
  localparam int PlanN         = 9;

  // One row of the directed table; the typed result is used when known is set
  typedef struct packed {
    logic [1:0]                op;
    logic [31:0]               sz;
    logic                      known;
    logic [tscm_pkg::FlW-1:0]  fl;
    logic [tscm_pkg::SlW-1:0]  sl;
    logic [tscm_pkg::AdjW-1:0] adj;
  } dir_row_t;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  tscm_pkg::req_t item = '0;
  logic result_valid;
  tscm_pkg::rsp_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [tscm_pkg::AlignW-1:0] cfg_data = '0;

  tscm_pkg::rsp_t expected_maps[$];
  logic [tscm_pkg::AlignW-1:0] align_now = tscm_pkg::AlignReset;
  int mismatches = 0;
  int idle_cycles = 0;
  bit no_gaps = 1'b0;

  // Directed rows at the reset alignment (4 bytes)
  dir_row_t dir_rows [DirN] = '{
    '{tscm_pkg::CMD_INSERT, 32'd0,          1'b1, 5'd0,  5'd0,  30'd0},
    '{tscm_pkg::CMD_INSERT, 32'd127,        1'b1, 5'd0,  5'd31, 30'd0},
    '{tscm_pkg::CMD_INSERT, 32'd128,        1'b1, 5'd1,  5'd0,  30'd0},
    '{tscm_pkg::CMD_INSERT, 32'h8000_0000,  1'b1, 5'd25, 5'd0,  30'd0},
    '{tscm_pkg::CMD_INSERT, 32'hFFFF_FFFF,  1'b1, 5'd25, 5'd31, 30'd0},
    '{tscm_pkg::CMD_INSERT, 32'h5555_5555,  1'b0, 5'd0,  5'd0,  30'd0},
    '{tscm_pkg::CMD_SEARCH, 32'd0,          1'b1, 5'd0,  5'd0,  30'd0},
    '{tscm_pkg::CMD_SEARCH, 32'd127,        1'b1, 5'd0,  5'd31, 30'd0},
    '{tscm_pkg::CMD_SEARCH, 32'd128,        1'b1, 5'd1,  5'd0,  30'd0},
    '{tscm_pkg::CMD_SEARCH, 32'hFFFF_FFFF,  1'b0, 5'd0,  5'd0,  30'd0},
    '{tscm_pkg::CMD_SEARCH, 32'hFC00_0001,  1'b1, 5'd0,  5'd0,  30'd0},
    '{tscm_pkg::CMD_SEARCH, 32'hFC00_0080,  1'b1, 5'd0,  5'd31, 30'd0},
    '{tscm_pkg::CMD_SEARCH, 32'h7FFF_FFFF,  1'b0, 5'd0,  5'd0,  30'd0},
    '{tscm_pkg::CMD_SEARCH, 32'hAAAA_AAAA,  1'b0, 5'd0,  5'd0,  30'd0},
    '{tscm_pkg::CMD_ADJUST, 32'd0,          1'b1, 5'd0,  5'd0,  30'd0},
    '{tscm_pkg::CMD_ADJUST, 32'd1,          1'b1, 5'd0,  5'd0,  30'd12},
    '{tscm_pkg::CMD_ADJUST, 32'd13,         1'b1, 5'd0,  5'd0,  30'd16},
    '{tscm_pkg::CMD_ADJUST, 32'h3FFF_FFFC,  1'b1, 5'd0,  5'd0,  30'h3FFF_FFFC},
    '{tscm_pkg::CMD_ADJUST, 32'h3FFF_FFFD,  1'b1, 5'd0,  5'd0,  30'd0},
    '{tscm_pkg::CMD_ADJUST, 32'hFFFF_FFFF,  1'b0, 5'd0,  5'd0,  30'd0},
    '{CmdUnknown,           32'hFFFF_FFFF,  1'b1, 5'd0,  5'd0,  30'd0},
    '{CmdUnknown,           32'h0001_2345,  1'b1, 5'd0,  5'd0,  30'd0}
  };

  // Alignments for the random phases, the extremes 0 and 15 included
  logic [tscm_pkg::AlignW-1:0] align_plan [PlanN] = '{
    4'd0, 4'd12, 4'd15, 4'd1, 4'd13, 4'd7, 4'd14, 4'd3, 4'd2
  };

  tlsf_size_class_mapper uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Position of the highest set bit
  function automatic int unsigned top_bit(logic [31:0] v);
    logic [31:0] w;
    int unsigned n;
    w = v;
    n = 0;
    while (w > 32'd1) begin
      w = w >> 1;
      n++;
    end
    return n;
  endfunction

  // Expected size class or adjusted size for one command
  function automatic tscm_pkg::rsp_t map_size(logic [1:0] op, logic [31:0] sz,
                                              logic [tscm_pkg::AlignW-1:0] align);
    tscm_pkg::rsp_t r;
    logic [31:0] v;
    logic [31:0] mask;
    int unsigned lg;
    r = '0;
    v = sz;
    case (op)
      tscm_pkg::CMD_INSERT, tscm_pkg::CMD_SEARCH: begin
        // search rounds up to the next class boundary, wrapping at 32 bits
        if (op == tscm_pkg::CMD_SEARCH && v >= SmallBound) begin
          lg = top_bit(v);
          v = v + ((32'd1 << (lg - SlBits)) - 32'd1);
        end
        if (v < SmallBound) begin
          r.sl_index = tscm_pkg::SlW'(v / SmallDivisor);
        end else begin
          lg = top_bit(v);
          r.fl_index = tscm_pkg::FlW'(lg - (FlShift - 1));
          r.sl_index = tscm_pkg::SlW'((v >> (lg - SlBits)) ^ SlCount);
        end
      end
      tscm_pkg::CMD_ADJUST: begin
        if (v != 32'd0) begin
          mask = (32'd1 << align) - 32'd1;
          v = (v + mask) & ~mask;
          if (v < tscm_pkg::BlockMax) begin
            r.adjusted_size = tscm_pkg::AdjW'((v > tscm_pkg::BlockMin) ? v : tscm_pkg::BlockMin);
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Random size, weighted towards class boundaries and wrap regions
  function automatic logic [31:0] pick_size();
    int unsigned k;
    case ($urandom_range(0, 10))
      0, 1, 2: return $urandom;
      3, 4:    return $urandom >> $urandom_range(0, 31);
      5:       return $urandom_range(0, 255);
      6:       return (32'd1 << $urandom_range(0, 31)) + $urandom_range(0, 8) - 32'd4;
      7:       return 32'hFC00_0000 + $urandom_range(0, 160);
      8:       return tscm_pkg::BlockMax - 32'h0001_0000 + $urandom_range(0, 32'h0002_0000);
      9:       return 32'hFFFF_FFFF - $urandom_range(0, 32'h0001_0000);
      default: begin
        // just below a power of two, so the search rounding crosses it
        k = $urandom_range(8, 31);
        return (32'd1 << k) - $urandom_range(1, 32'd1 << (k - 6));
      end
    endcase
  endfunction

  function automatic logic [1:0] pick_cmd();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 31) return tscm_pkg::CMD_INSERT;
    if (r < 62) return tscm_pkg::CMD_SEARCH;
    if (r < 93) return tscm_pkg::CMD_ADJUST;
    return CmdUnknown;
  endfunction

  // Issue one command and record what it should produce
  task automatic issue_cmd(logic [1:0] op, logic [31:0] sz, logic known,
                           tscm_pkg::rsp_t typed);
    int unsigned gap;
    tscm_pkg::req_t req;
    gap = no_gaps ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.cmd  = tscm_pkg::cmd_t'(op);
    req.size = sz;
    start <= 1'b1;
    item  <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_maps.push_back(known ? typed : map_size(op, sz, align_now));
  endtask

  // Let the pipeline empty, then change the alignment
  task automatic set_alignment(logic [tscm_pkg::AlignW-1:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (expected_maps.size() != 0) @(posedge clk);
    repeat (LatencyCycles) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    align_now = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic flag_mismatch(string what);
    if (mismatches < ReportLimit) $display("%0t: %s", $realtime, what);
    mismatches++;
  endtask

  // Result checker
  always @(posedge clk) begin
    tscm_pkg::rsp_t want;
    if (!rst && result_valid) begin
      if (expected_maps.size() == 0) begin
        flag_mismatch($sformatf("unexpected result fl=%0d sl=%0d adj=%0h",
                                result.fl_index, result.sl_index, result.adjusted_size));
      end else begin
        want = expected_maps.pop_front();
        if (result.fl_index !== want.fl_index ||
            result.sl_index !== want.sl_index ||
            result.adjusted_size !== want.adjusted_size)
          flag_mismatch($sformatf("expected fl=%0d sl=%0d adj=%0h, got fl=%0d sl=%0d adj=%0h",
                                  want.fl_index, want.sl_index, want.adjusted_size,
                                  result.fl_index, result.sl_index,
                                  result.adjusted_size));
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("tlsf_size_class_mapper test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    tscm_pkg::rsp_t typed;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table at the reset alignment
    for (int i = 0; i < DirN; i++) begin
      typed = '{fl_index: dir_rows[i].fl, sl_index: dir_rows[i].sl,
                adjusted_size: dir_rows[i].adj};
      issue_cmd(dir_rows[i].op, dir_rows[i].sz, dir_rows[i].known, typed);
    end

    // Random phases, one alignment each
    for (int p = 0; p < PlanN; p++) begin
      set_alignment(align_plan[p]);
      for (int n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(0, 39) == 0) no_gaps = !no_gaps;
        issue_cmd(pick_cmd(), pick_size(), 1'b0, '0);
      end
    end

    // Drain
    start <= 1'b0;
    @(posedge clk);
    while (expected_maps.size() != 0) @(posedge clk);
    repeat (LatencyCycles + 4) @(posedge clk);
    if (mismatches == 0 && expected_maps.size() == 0) begin
      $display("tlsf_size_class_mapper test passed");
    end else begin
      $display("tlsf_size_class_mapper test failed");
    end
    $finish;
  end

endmodule
